FILE: hdl/tcch_pkg.sv
// ----------------------------------------------------------------------------
// tcch_pkg
// constants and cordic arctangent table for the compass heading core
// ----------------------------------------------------------------------------
`default_nettype none
package tcch_pkg;
    localparam int unsigned CORDIC_STEPS = 20;
    localparam int unsigned ANG_SHIFT    = 8;
    localparam int unsigned ANG_W        = 24;
    localparam int unsigned SC_W         = 33;
    localparam int unsigned VX_W         = 34;
    localparam logic signed [SC_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [ANG_W-1:0] DEG180 = 24'sd4608000;
    localparam logic signed [ANG_W-1:0] DEG360_CDEG = 24'sd36000;

    function automatic logic signed [ANG_W-1:0] atan_tab(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        begin
            case (idx)
                5'd0:  v = 24'sd1152000;
                5'd1:  v = 24'sd680065;
                5'd2:  v = 24'sd359328;
                5'd3:  v = 24'sd182400;
                5'd4:  v = 24'sd91554;
                5'd5:  v = 24'sd45822;
                5'd6:  v = 24'sd22916;
                5'd7:  v = 24'sd11459;
                5'd8:  v = 24'sd5730;
                5'd9:  v = 24'sd2865;
                5'd10: v = 24'sd1432;
                5'd11: v = 24'sd716;
                5'd12: v = 24'sd358;
                5'd13: v = 24'sd179;
                5'd14: v = 24'sd90;
                5'd15: v = 24'sd45;
                5'd16: v = 24'sd22;
                5'd17: v = 24'sd11;
                5'd18: v = 24'sd6;
                5'd19: v = 24'sd3;
                default: v = '0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

FILE: hdl/tilt_compensated_compass_heading_core.sv
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_core
// throughput: one sample per cycle, set by one register stage per cordic
// iteration in each cordic
// reset: synchronous, active low, clears the valid pipeline only
// busy is always low; results are a single-cycle strobe on o_valid
// ----------------------------------------------------------------------------
`default_nettype none
module tilt_compensated_compass_heading_core
    import tcch_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire signed  [11:0] i_mag_x,
    input  wire signed  [11:0] i_mag_y,
    input  wire signed  [11:0] i_mag_z,
    input  wire signed  [15:0] i_roll_angle,
    input  wire signed  [15:0] i_pitch_angle,
    output logic               o_valid,
    output logic signed [12:0] o_horiz_x,
    output logic signed [12:0] o_horiz_y,
    output logic        [15:0] o_heading
);
    localparam int unsigned N = CORDIC_STEPS;
    // stage plan: 0 reduce, 1..N sincos, N+1 prod1, N+2 prod2, N+3 sum/trunc,
    // N+4 vector prep, N+5..2N+4 vectoring, 2N+5 round, 2N+6..  output reg
    localparam int unsigned LAT = 2 * N + 10;

    assign busy = 1'b0;

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    // ---------------- stage A: angle reduction
    function automatic logic signed [15:0] reduce(input logic signed [15:0] a,
                                                  output logic neg);
        logic signed [17:0] t;
        begin
            t = 18'(a);
            if (t > 18'sd18000) t = t - 18'sd36000;
            else if (t < -18'sd18000) t = t + 18'sd36000;
            // +18000 is mapped to -18000; -18000 is kept as it is
            if (t == 18'sd18000) t = -18'sd18000;
            neg = 1'b0;
            if (t > 18'sd9000) begin
                t = t - 18'sd18000; neg = 1'b1;
            end else if (t < -18'sd9000) begin
                t = t + 18'sd18000; neg = 1'b1;
            end
            return t[15:0];
        end
    endfunction

    logic signed [11:0] r_mx [0:N+1];
    logic signed [11:0] r_my [0:N+1];
    logic signed [11:0] r_mz [0:N+1];
    logic               r_rn [0:N];
    logic               r_pn [0:N];
    logic signed [SC_W-1:0]  r_rx [0:N];
    logic signed [SC_W-1:0]  r_ry [0:N];
    logic signed [ANG_W-1:0] r_rz [0:N];
    logic signed [SC_W-1:0]  r_px [0:N];
    logic signed [SC_W-1:0]  r_py [0:N];
    logic signed [ANG_W-1:0] r_pz [0:N];

    logic signed [15:0] n_ra, n_pa;
    logic n_rn, n_pn;
    always_comb begin
        n_ra = reduce(i_roll_angle, n_rn);
        n_pa = reduce(i_pitch_angle, n_pn);
    end

    always_ff @(posedge i_clk) begin
        r_mx[0] <= i_mag_x;
        r_my[0] <= i_mag_y;
        r_mz[0] <= i_mag_z;
        r_rn[0] <= n_rn;
        r_pn[0] <= n_pn;
        r_rx[0] <= CORDIC_GAIN;
        r_ry[0] <= '0;
        r_rz[0] <= ANG_W'(n_ra) <<< ANG_SHIFT;
        r_px[0] <= CORDIC_GAIN;
        r_py[0] <= '0;
        r_pz[0] <= ANG_W'(n_pa) <<< ANG_SHIFT;
        for (int k = 1; k <= N + 1; k++) begin
            r_mx[k] <= r_mx[k-1];
            r_my[k] <= r_my[k-1];
            r_mz[k] <= r_mz[k-1];
        end
    end

    // ---------------- rotation cordic stages
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_rot
            always_ff @(posedge i_clk) begin
                r_rn[g+1] <= r_rn[g];
                r_pn[g+1] <= r_pn[g];
                if (r_rz[g] >= 0) begin
                    r_rx[g+1] <= r_rx[g] - (r_ry[g] >>> g);
                    r_ry[g+1] <= r_ry[g] + (r_rx[g] >>> g);
                    r_rz[g+1] <= r_rz[g] - atan_tab(5'(g));
                end else begin
                    r_rx[g+1] <= r_rx[g] + (r_ry[g] >>> g);
                    r_ry[g+1] <= r_ry[g] - (r_rx[g] >>> g);
                    r_rz[g+1] <= r_rz[g] + atan_tab(5'(g));
                end
                if (r_pz[g] >= 0) begin
                    r_px[g+1] <= r_px[g] - (r_py[g] >>> g);
                    r_py[g+1] <= r_py[g] + (r_px[g] >>> g);
                    r_pz[g+1] <= r_pz[g] - atan_tab(5'(g));
                end else begin
                    r_px[g+1] <= r_px[g] + (r_py[g] >>> g);
                    r_py[g+1] <= r_py[g] - (r_px[g] >>> g);
                    r_pz[g+1] <= r_pz[g] + atan_tab(5'(g));
                end
            end
        end
    endgenerate

    logic signed [SC_W-1:0] w_sr, w_cr, w_sp, w_cp;
    assign w_sr = r_rn[N] ? -r_ry[N] : r_ry[N];
    assign w_cr = r_rn[N] ? -r_rx[N] : r_rx[N];
    assign w_sp = r_pn[N] ? -r_py[N] : r_py[N];
    assign w_cp = r_pn[N] ? -r_px[N] : r_px[N];

    // ---------------- products (q30), sr*sp and cr*sp
    logic signed [SC_W-1:0] r_srsp, r_crsp, r_cr1, r_sr1, r_cp1;
    logic signed [2*SC_W-1:0] w_p1, w_p2;
    assign w_p1 = 66'(w_sr) * 66'(w_sp);
    assign w_p2 = 66'(w_cr) * 66'(w_sp);
    always_ff @(posedge i_clk) begin
        r_srsp <= SC_W'(w_p1 >>> 30);
        r_crsp <= SC_W'(w_p2 >>> 30);
        r_cr1  <= w_cr;
        r_sr1  <= w_sr;
        r_cp1  <= w_cp;
    end

    logic signed [46:0] r_t0, r_t1, r_t2, r_t3, r_t4;
    always_ff @(posedge i_clk) begin
        r_t0 <= 47'(r_mx[N+1]) * 47'(r_cp1);
        r_t1 <= 47'(r_my[N+1]) * 47'(r_srsp);
        r_t2 <= 47'(r_mz[N+1]) * 47'(r_crsp);
        r_t3 <= 47'(r_my[N+1]) * 47'(r_cr1);
        r_t4 <= 47'(r_mz[N+1]) * 47'(r_sr1);
    end

    // ---------------- sum, truncate toward zero, saturate
    function automatic logic signed [12:0] trunc_sat(input logic signed [46:0] v);
        logic signed [46:0] q;
        begin
            q = (v < 0) ? -((-v) >>> 30) : (v >>> 30);
            if (q > 47'sd4095) q = 47'sd4095;
            else if (q < -47'sd4096) q = -47'sd4096;
            return q[12:0];
        end
    endfunction

    logic signed [12:0] r_hx [0:N+2];
    logic signed [12:0] r_hy [0:N+2];
    always_ff @(posedge i_clk) begin
        r_hx[0] <= trunc_sat(r_t0 + r_t1 - r_t2);
        r_hy[0] <= trunc_sat(r_t3 + r_t4);
        for (int k = 1; k <= N + 2; k++) begin
            r_hx[k] <= r_hx[k-1];
            r_hy[k] <= r_hy[k-1];
        end
    end

    // ---------------- vectoring cordic
    logic signed [VX_W-1:0]  r_vx [0:N];
    logic signed [VX_W-1:0]  r_vy [0:N];
    logic signed [ANG_W:0]   r_vz [0:N];
    logic signed [VX_W-1:0]  w_x0, w_y0;
    assign w_x0 = VX_W'(r_hx[0]) <<< 16;
    assign w_y0 = VX_W'(r_hy[0]) <<< 16;
    always_ff @(posedge i_clk) begin
        if (w_x0 < 0) begin
            r_vx[0] <= -w_x0;
            r_vy[0] <= -w_y0;
            r_vz[0] <= (w_y0 >= 0) ? (ANG_W+1)'(DEG180) : -(ANG_W+1)'(DEG180);
        end else begin
            r_vx[0] <= w_x0;
            r_vy[0] <= w_y0;
            r_vz[0] <= '0;
        end
    end
    generate
        for (g = 0; g < N; g++) begin : g_vec
            always_ff @(posedge i_clk) begin
                if (r_vy[g] >= 0) begin
                    r_vx[g+1] <= r_vx[g] + (r_vy[g] >>> g);
                    r_vy[g+1] <= r_vy[g] - (r_vx[g] >>> g);
                    r_vz[g+1] <= r_vz[g] + (ANG_W+1)'(atan_tab(5'(g)));
                end else begin
                    r_vx[g+1] <= r_vx[g] - (r_vy[g] >>> g);
                    r_vy[g+1] <= r_vy[g] + (r_vx[g] >>> g);
                    r_vz[g+1] <= r_vz[g] - (ANG_W+1)'(atan_tab(5'(g)));
                end
            end
        end
    endgenerate

    // ---------------- rounding and wrap
    logic signed [ANG_W:0] w_hr;
    logic signed [ANG_W:0] r_h;
    logic                  r_zero;
    assign w_hr = (r_vz[N] + (ANG_W+1)'(1 << (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    always_ff @(posedge i_clk) begin
        r_h    <= w_hr;
        r_zero <= (r_hx[N+1] == '0) && (r_hy[N+1] == '0);
    end

    logic signed [ANG_W:0] w_hw;
    always_comb begin
        w_hw = r_h;
        if (w_hw < 0) w_hw = w_hw + (ANG_W+1)'(DEG360_CDEG);
        if (w_hw > (ANG_W+1)'(DEG360_CDEG)) w_hw = w_hw - (ANG_W+1)'(DEG360_CDEG);
        if (r_zero) w_hw = '0;
    end

    // pipeline length check: 1 + N + 1 + 1 + 1 + 1 + N + 1 = 2N+6 data
    // stages; valid chain padded by delaying output
    localparam int unsigned DLY = LAT - (2 * N + 6);
    logic [15:0]        r_hd [0:DLY-1];
    logic signed [12:0] r_ox [0:DLY-1];
    logic signed [12:0] r_oy [0:DLY-1];
    always_ff @(posedge i_clk) begin
        r_hd[0] <= w_hw[15:0];
        r_ox[0] <= r_hx[N+2];
        r_oy[0] <= r_hy[N+2];
        for (int k = 1; k < DLY; k++) begin
            r_hd[k] <= r_hd[k-1];
            r_ox[k] <= r_ox[k-1];
            r_oy[k] <= r_oy[k-1];
        end
    end

    assign o_valid   = r_vld[LAT-1];
    assign o_heading = r_hd[DLY-1];
    assign o_horiz_x = r_ox[DLY-1];
    assign o_horiz_y = r_oy[DLY-1];
endmodule
`default_nettype wire

FILE: hdl/tcch_checker.sv
// ----------------------------------------------------------------------------
// tcch_checker
// port-level checks on the compass heading core
// ----------------------------------------------------------------------------
`default_nettype none
module tcch_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               start,
    input wire               busy,
    input wire               o_valid,
    input wire signed [12:0] o_horiz_x,
    input wire signed [12:0] o_horiz_y,
    input wire        [15:0] o_heading
);
    a_never_busy: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy raised");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_heading <= 16'd36000)) else $error("heading out of range");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_horiz_x == 13'sd0 && o_horiz_y == 13'sd0) |-> (o_heading == 16'd0))
        else $error("zero vector heading not zero");
    a_east: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_horiz_y == 13'sd0 && o_horiz_x > 13'sd0) |->
        (o_heading == 16'd0 || o_heading == 16'd36000)) else $error("east heading");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind tilt_compensated_compass_heading_core tcch_checker u_tcch_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_horiz_x(o_horiz_x), .o_horiz_y(o_horiz_y),
    .o_heading(o_heading)
);
`default_nettype wire
